/* hw/rtl/vaqs_pkg.sv */
// Shared types and constants for the voice allocator with quietest-voice stealing.
package vaqs_pkg;

  localparam int unsigned SlotW  = 5;
  localparam int unsigned GainW  = 16;
  localparam int unsigned ActW   = 6;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;

  localparam logic [ActW-1:0] ActiveReset = 6'd32;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_GAIN    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_VOICE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MODIFY,
    S_SCAN,
    S_FINISH
  } state_e;

  // One voice record as kept in the voice memory
  typedef struct packed {
    logic             busy;
    logic             streaming;
    logic [GainW-1:0] gain;
  } voice_t;

endpackage

/* hw/rtl/vaqs_voice_mem.sv */
// Voice record memory: one write port, one registered read port, reset-cleared valid bits.
module vaqs_voice_mem #(
  parameter int unsigned VOICES = 32,
  parameter int unsigned IW     = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IW-1:0]     rd_addr_i,
  output vaqs_pkg::voice_t  rd_data_o,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_addr_i,
  input  vaqs_pkg::voice_t  wr_data_i
);

  vaqs_pkg::voice_t mem [VOICES];
  logic [VOICES-1:0] vld_q;
  vaqs_pkg::voice_t  rd_q;
  logic              rd_vld_q;

  // Write the record array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Mark written entries; reset returns every entry to its cleared value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Register the read data and its valid bit
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // An unwritten entry reads as free, not streaming, zero gain
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* hw/rtl/voice_allocator_quietest_steal.sv */
// Voice allocator: round-robin free-voice search with quietest-voice stealing.
// Allocate: round-robin scan, ending early when a free voice is found; one voice record is
// read per cycle from the voice memory during the scan. Release and set-gain: read, write
// back, result; straight to the result for a bad slot, an unused op or an empty pool.
// The next input transfer is taken the cycle after the output register loads.
// Reset clears all voices at once through per-entry valid bits; pool size resets to 32, capped at VOICES.
module voice_allocator_quietest_steal #(
  parameter int unsigned VOICES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vaqs_pkg::ActW-1:0]    cfg_data_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [vaqs_pkg::OpW-1:0]     op_i,
  input  logic [vaqs_pkg::SlotW-1:0]   slot_i,
  input  logic [vaqs_pkg::GainW-1:0]   gain_i,
  input  logic                         owner_streaming_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vaqs_pkg::SlotW-1:0]   granted_slot_o,
  output logic                         stole_o,
  output logic [vaqs_pkg::StatW-1:0]   status_o
);

  localparam int unsigned IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned XW = ((IW > vaqs_pkg::SlotW) ? IW : vaqs_pkg::SlotW) + 1;

  typedef logic [XW-1:0] idx_t;

  vaqs_pkg::state_e  state_q, state_d;
  logic [vaqs_pkg::ActW-1:0] active_q;
  logic [IW-1:0]     sp_q;

  vaqs_pkg::op_e     op_q;
  idx_t              slot_q;
  logic [vaqs_pkg::GainW-1:0] gain_q;
  logic              os_q;

  idx_t              iss_idx_q;
  idx_t              iss_cnt_q;
  logic              ev_vld_q;
  idx_t              ev_idx_q;
  logic              have_q;
  idx_t              best_idx_q;
  logic [vaqs_pkg::GainW-1:0] best_gain_q;

  idx_t              res_slot_q;
  logic              res_stole_q;
  vaqs_pkg::status_e res_status_q;

  logic              out_valid_q;
  logic [vaqs_pkg::SlotW-1:0] out_slot_q;
  logic              out_stole_q;
  vaqs_pkg::status_e out_status_q;

  idx_t              pool_n;
  idx_t              slot_x;
  idx_t              start_p;
  logic              slot_bad;
  logic              in_xfer;
  logic              out_free;
  logic              issue;
  logic              found;
  logic              scan_done;
  logic              cand;
  vaqs_pkg::status_e first_status;

  logic [IW-1:0]     rd_addr;
  vaqs_pkg::voice_t  rd_voice;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  vaqs_pkg::voice_t  wr_data;

  vaqs_voice_mem #(
    .VOICES (VOICES),
    .IW     (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_voice),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Pool size and handshake terms
  assign pool_n   = (idx_t'(active_q) < idx_t'(VOICES)) ? idx_t'(active_q) : idx_t'(VOICES);
  assign slot_x   = idx_t'(slot_i);
  assign slot_bad = (slot_x >= pool_n);
  assign start_p  = (idx_t'(sp_q) < pool_n) ? idx_t'(sp_q) : '0;

  assign in_stall_o  = (state_q != vaqs_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Scan terms: issue one read per cycle, evaluate the returning record
  assign found     = (state_q == vaqs_pkg::S_SCAN) && ev_vld_q && !rd_voice.busy;
  assign issue     = (state_q == vaqs_pkg::S_SCAN) && (iss_cnt_q < pool_n) && !found;
  assign scan_done = (state_q == vaqs_pkg::S_SCAN) && !found && !ev_vld_q
                     && (iss_cnt_q == pool_n);
  assign cand      = ev_vld_q && rd_voice.busy && !rd_voice.streaming
                     && (!have_q || (rd_voice.gain < best_gain_q)
                         || ((rd_voice.gain == best_gain_q) && (ev_idx_q < best_idx_q)));

  // Status known at the input transfer
  always_comb begin
    first_status = vaqs_pkg::ST_OK;
    unique case (vaqs_pkg::op_e'(op_i))
      vaqs_pkg::OP_ALLOC: begin
        if (pool_n == '0) begin
          first_status = vaqs_pkg::ST_NO_VOICE;
        end
      end
      vaqs_pkg::OP_RELEASE, vaqs_pkg::OP_GAIN: begin
        if (slot_bad) begin
          first_status = vaqs_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vaqs_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (vaqs_pkg::op_e'(op_i))
            vaqs_pkg::OP_ALLOC: begin
              state_d = (pool_n == '0) ? vaqs_pkg::S_FINISH : vaqs_pkg::S_SCAN;
            end
            vaqs_pkg::OP_RELEASE, vaqs_pkg::OP_GAIN: begin
              state_d = slot_bad ? vaqs_pkg::S_FINISH : vaqs_pkg::S_MODIFY;
            end
            default: state_d = vaqs_pkg::S_FINISH;
          endcase
        end
      end
      vaqs_pkg::S_MODIFY: state_d = vaqs_pkg::S_FINISH;
      vaqs_pkg::S_SCAN: begin
        if (found || scan_done) begin
          state_d = vaqs_pkg::S_FINISH;
        end
      end
      vaqs_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = vaqs_pkg::S_IDLE;
        end
      end
      default: state_d = vaqs_pkg::S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_addr = (state_q == vaqs_pkg::S_SCAN) ? iss_idx_q[IW-1:0] : slot_x[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = slot_q[IW-1:0];
    wr_data = rd_voice;
    unique case (state_q)
      vaqs_pkg::S_MODIFY: begin
        wr_en = 1'b1;
        if (op_q == vaqs_pkg::OP_RELEASE) begin
          wr_data.busy      = 1'b0;
          wr_data.streaming = 1'b0;
        end else begin
          wr_data.gain = gain_q;
        end
      end
      vaqs_pkg::S_SCAN: begin
        wr_data.busy      = 1'b1;
        wr_data.streaming = os_q;
        wr_data.gain      = '0;
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = ev_idx_q[IW-1:0];
        end else if (scan_done && have_q) begin
          wr_en   = 1'b1;
          wr_addr = best_idx_q[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vaqs_pkg::S_IDLE;
      active_q <= vaqs_pkg::ActiveReset;
      sp_q     <= '0;
      ev_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ev_vld_q <= issue;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
      // Leave the search pointer on the granted voice
      if (found) begin
        sp_q <= ev_idx_q[IW-1:0];
      end else if (scan_done && have_q) begin
        sp_q <= best_idx_q[IW-1:0];
      end
    end
  end

  // Item, scan and result registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q         <= vaqs_pkg::op_e'(op_i);
      slot_q       <= slot_x;
      gain_q       <= gain_i;
      os_q         <= owner_streaming_i;
      iss_idx_q    <= start_p;
      iss_cnt_q    <= '0;
      have_q       <= 1'b0;
      best_idx_q   <= '0;
      best_gain_q  <= '0;
      res_slot_q   <= '0;
      res_stole_q  <= 1'b0;
      res_status_q <= first_status;
    end
    // Advance the round-robin read index, wrapping at the pool end
    if (issue) begin
      iss_idx_q <= ((iss_idx_q + idx_t'(1)) == pool_n) ? '0 : iss_idx_q + idx_t'(1);
      iss_cnt_q <= iss_cnt_q + idx_t'(1);
    end
    ev_idx_q <= iss_idx_q;
    // Track the quietest non-streaming busy voice
    if ((state_q == vaqs_pkg::S_SCAN) && cand) begin
      have_q      <= 1'b1;
      best_idx_q  <= ev_idx_q;
      best_gain_q <= rd_voice.gain;
    end
    if (found) begin
      res_slot_q <= ev_idx_q;
    end else if (scan_done) begin
      if (have_q) begin
        res_slot_q  <= best_idx_q;
        res_stole_q <= 1'b1;
      end else begin
        res_status_q <= vaqs_pkg::ST_NO_VOICE;
      end
    end
  end

  // Output register: load on finish, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == vaqs_pkg::S_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == vaqs_pkg::S_FINISH) && out_free) begin
      out_slot_q   <= res_slot_q[vaqs_pkg::SlotW-1:0];
      out_stole_q  <= res_stole_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = out_slot_q;
  assign stole_o        = out_stole_q;
  assign status_o       = out_status_q;

endmodule
